FILE: src/fms_pkg.sv
// Shared types and constants for the fuzzy match scorer.
// Used by the interfaces and by every module of the block; no dependencies.
package fms_pkg;

  localparam int CHAR_W  = 16;
  localparam int SCORE_W = 12;
  localparam int POS_W   = 5;
  localparam int RUN_W   = 5;
  localparam int ADD_W   = 9;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 2;
  localparam int QBYTES  = 16;

  localparam logic [ADD_W-1:0] FIRST_BONUS    = 9'd100;
  localparam logic [ADD_W-1:0] BOUNDARY_BONUS = 9'd50;
  localparam logic [ADD_W-1:0] RUN_WEIGHT     = 9'd10;

  typedef enum logic [CIDX_W-1:0] {
    REG_QUERY_LOW  = 2'd0,
    REG_QUERY_HIGH = 2'd1,
    REG_QUERY_LEN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } char_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] match_score;
    logic               query_found;
  } result_t;

endpackage

FILE: src/fms_if.sv
// Handshake channels of the fuzzy match scorer: text characters in, scores out.
// Depends on fms_pkg for field widths.
interface fms_char_if;
  logic                       valid;
  logic                       ready;
  logic [fms_pkg::CHAR_W-1:0] text_char;
  logic                       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface fms_result_if;
  logic                        valid;
  logic                        ready;
  logic [fms_pkg::SCORE_W-1:0] match_score;
  logic                        query_found;

  modport source (output valid, output match_score, output query_found, input ready);
  modport sink   (input valid, input match_score, input query_found, output ready);
endinterface

FILE: src/fuzzy_match_scorer_unit.sv
// Fuzzy subsequence match scorer: one text character per cycle, one score per string;
// a last character waits until the result register is free. The result is loaded into
// the result register when the last character advances out of the input register (the
// input register feeds the result register through the score core).
// Reset (rst, synchronous) clears the query registers, per-string state and valids.
module fuzzy_match_scorer_unit #(
  parameter int QUERY_CHARS = 16,
  parameter int TEXT_CHARS  = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [fms_pkg::CIDX_W-1:0] cfg_index,
  input  logic [fms_pkg::CFG_W-1:0]  cfg_data,
  fms_char_if.sink                   char_in,
  fms_result_if.source               result_out
);

  logic                item_valid;
  fms_pkg::char_item_t item;
  fms_pkg::result_t    result;
  logic                out_free;
  logic                fire;

  // Advance a plain character at once; a last character waits for a free result slot
  assign fire = item_valid && (!item.last_char || out_free);

  fms_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  fms_score_core #(
    .QUERY_CHARS (QUERY_CHARS),
    .TEXT_CHARS  (TEXT_CHARS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  fms_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (fire && item.last_char),
    .result     (result),
    .free       (out_free),
    .result_out (result_out)
  );

endmodule

FILE: src/fms_in_reg.sv
// Input register of the scorer: holds one character until the core consumes it.
// Depends on fms_pkg and fms_char_if.
module fms_in_reg (
  input  logic                clk,
  input  logic                rst,
  fms_char_if.sink            char_in,
  input  logic                advance,
  output logic                item_valid,
  output fms_pkg::char_item_t item
);

  assign char_in.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (char_in.ready) begin
      item_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      item.text_char <= char_in.text_char;
      item.last_char <= char_in.last_char;
    end
  end

endmodule

FILE: src/fms_score_core.sv
// Query registers, per-string match state and the single-pass score update.
// Depends on fms_pkg.
module fms_score_core #(
  parameter int QUERY_CHARS = 16,
  parameter int TEXT_CHARS  = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [fms_pkg::CIDX_W-1:0] cfg_index,
  input  logic [fms_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       fire,
  input  fms_pkg::char_item_t        item,
  output fms_pkg::result_t           result
);

  localparam int SEEN_W = $clog2(TEXT_CHARS + 1);
  localparam int CMP_W  = (SEEN_W > fms_pkg::SCORE_W) ? SEEN_W : fms_pkg::SCORE_W;

  logic [fms_pkg::CFG_W-1:0]   query_chars_low;
  logic [fms_pkg::CFG_W-1:0]   query_chars_high;
  logic [fms_pkg::POS_W-1:0]   query_length;

  logic [fms_pkg::POS_W-1:0]   query_position, query_position_next;
  logic [fms_pkg::SCORE_W-1:0] running_score, running_score_next;
  logic [fms_pkg::RUN_W-1:0]   consecutive_run, consecutive_run_next;
  logic                        previous_was_alnum, previous_was_alnum_next;
  logic [SEEN_W-1:0]           characters_seen, characters_seen_next;

  logic [fms_pkg::POS_W-1:0]   active_len;
  logic [2*fms_pkg::CFG_W-1:0] query_all;
  logic [7:0]                  query_byte;
  logic                        first_char;
  logic                        is_alnum;
  logic                        char_hit;
  logic [fms_pkg::RUN_W-1:0]   run_inc;
  logic [fms_pkg::ADD_W-1:0]   add;
  logic                        found;
  logic [CMP_W-1:0]            score_ext, seen_ext, diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_chars_low  <= '0;
      query_chars_high <= '0;
      query_length     <= '0;
    end else if (cfg_write) begin
      case (fms_pkg::cfg_reg_t'(cfg_index))
        fms_pkg::REG_QUERY_LOW:  query_chars_low  <= cfg_data;
        fms_pkg::REG_QUERY_HIGH: query_chars_high <= cfg_data;
        fms_pkg::REG_QUERY_LEN:  query_length     <= cfg_data[fms_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign active_len = (query_length > fms_pkg::POS_W'(QUERY_CHARS))
                      ? fms_pkg::POS_W'(QUERY_CHARS) : query_length;
  assign query_all  = {query_chars_high, query_chars_low};
  assign query_byte = query_all[query_position[3:0]*8 +: 8];
  assign first_char = (characters_seen == '0);

  assign is_alnum = (item.text_char >= 16'h0030 && item.text_char <= 16'h0039) ||
                    (item.text_char >= 16'h0041 && item.text_char <= 16'h005A) ||
                    (item.text_char >= 16'h0061 && item.text_char <= 16'h007A);

  assign char_hit = (item.text_char == {8'h00, query_byte});
  assign run_inc  = consecutive_run + 1'b1;

  always_comb begin
    add = fms_pkg::ADD_W'(run_inc) * fms_pkg::RUN_WEIGHT;
    if (first_char) begin
      add = add + fms_pkg::FIRST_BONUS;
    end
    if (first_char || !previous_was_alnum) begin
      add = add + fms_pkg::BOUNDARY_BONUS;
    end
  end

  always_comb begin
    query_position_next  = query_position;
    running_score_next   = running_score;
    consecutive_run_next = consecutive_run;
    if (query_position < active_len) begin
      if (char_hit) begin
        consecutive_run_next = run_inc;
        running_score_next   = running_score + fms_pkg::SCORE_W'(add);
        query_position_next  = query_position + 1'b1;
      end else begin
        consecutive_run_next = '0;
      end
    end
    previous_was_alnum_next = is_alnum;
    characters_seen_next    = characters_seen;
    if (characters_seen != SEEN_W'(TEXT_CHARS)) begin
      characters_seen_next = characters_seen + 1'b1;
    end
  end

  // Final score from the updated state of the last character
  assign found     = (query_position_next >= active_len);
  assign score_ext = CMP_W'(running_score_next);
  assign seen_ext  = CMP_W'(characters_seen_next);
  assign diff      = score_ext - seen_ext;

  always_comb begin
    result.query_found = found;
    result.match_score = '0;
    if (found && score_ext > seen_ext) begin
      result.match_score = diff[fms_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_char)) begin
      query_position     <= '0;
      running_score      <= '0;
      consecutive_run    <= '0;
      previous_was_alnum <= 1'b0;
      characters_seen    <= '0;
    end else if (fire) begin
      query_position     <= query_position_next;
      running_score      <= running_score_next;
      consecutive_run    <= consecutive_run_next;
      previous_was_alnum <= previous_was_alnum_next;
      characters_seen    <= characters_seen_next;
    end
  end

endmodule

FILE: src/fms_out_reg.sv
// Result register of the scorer: holds one score until the sink takes it.
// Depends on fms_pkg and fms_result_if.
module fms_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fms_pkg::result_t result,
  output logic             free,
  fms_result_if.source     result_out
);

  assign free = !result_out.valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (free) begin
      result_out.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result_out.match_score <= result.match_score;
      result_out.query_found <= result.query_found;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for fuzzy_match_scorer_unit: streams text characters, rewrites
// the query between and within strings, and scores every result against an in-bench predictor.
// Depends on fms_pkg, fms_char_if and fms_result_if from the RTL sources.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUERY_MAX     = 16;
  localparam int TEXT_LIMIT    = 256;
  localparam int START_BONUS   = 100;
  localparam int WORD_BONUS    = 50;
  localparam int RUN_STEP      = 10;
  localparam int RANDOM_CHARS  = 1150;
  localparam int SETTLE_CYCLES = 4;

  // Predicts the score of each string and holds the scores still owed by the block.
  class fuzzy_score_checker;
    logic [fms_pkg::CFG_W-1:0]   query_low;
    logic [fms_pkg::CFG_W-1:0]   query_high;
    logic [fms_pkg::POS_W-1:0]   query_len;
    logic [fms_pkg::POS_W-1:0]   position;
    logic [fms_pkg::SCORE_W-1:0] score;
    logic [fms_pkg::RUN_W-1:0]   run;
    bit                          prev_alnum;
    int unsigned                 seen;
    fms_pkg::result_t            pending_scores[$];
    int unsigned                 error_count;

    function new();
      query_low   = '0;
      query_high  = '0;
      query_len   = '0;
      error_count = 0;
      clear_string();
    endfunction

    function void clear_string();
      position   = '0;
      score      = '0;
      run        = '0;
      prev_alnum = 1'b0;
      seen       = 0;
    endfunction

    function void set_register(logic [fms_pkg::CIDX_W-1:0] idx,
                               logic [fms_pkg::CFG_W-1:0] data);
      case (idx)
        fms_pkg::REG_QUERY_LOW:  query_low  = data;
        fms_pkg::REG_QUERY_HIGH: query_high = data;
        fms_pkg::REG_QUERY_LEN:  query_len  = data[fms_pkg::POS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned waiting();
      return pending_scores.size();
    endfunction

    function void take_char(logic [fms_pkg::CHAR_W-1:0] c, logic last);
      int unsigned      span;
      int unsigned      add;
      logic [7:0]       qbyte;
      fms_pkg::result_t r;
      span = (query_len > QUERY_MAX) ? QUERY_MAX : query_len;
      if (position < span) begin
        qbyte = (position < 8) ? query_low[8*position[2:0] +: 8]
                               : query_high[8*position[2:0] +: 8];
        if (c == {8'h00, qbyte}) begin
          add = 0;
          if (seen == 0) add += START_BONUS;
          if (seen == 0 || !prev_alnum) add += WORD_BONUS;
          run = run + 1'b1;
          add += run * RUN_STEP;
          score = score + add[fms_pkg::SCORE_W-1:0];
          position = position + 1'b1;
        end else begin
          run = '0;
        end
      end
      prev_alnum = (c >= 16'h0030 && c <= 16'h0039) || (c >= 16'h0041 && c <= 16'h005A) ||
                   (c >= 16'h0061 && c <= 16'h007A);
      if (seen < TEXT_LIMIT) seen++;
      if (last) begin
        r.query_found = (position >= span);
        r.match_score = (r.query_found && score > seen)
                        ? score - seen[fms_pkg::SCORE_W-1:0] : '0;
        pending_scores = {pending_scores, r};
        clear_string();
      end
    endfunction

    function void check_score(fms_pkg::result_t got);
      fms_pkg::result_t want;
      if (pending_scores.size() == 0) begin
        $display("%0t: result with nothing expected, actual score %0d found %0d",
                 $time, got.match_score, got.query_found);
        error_count++;
        return;
      end
      want = pending_scores.pop_front();
      if (got.match_score !== want.match_score) begin
        $display("%0t: match_score mismatch, expected %0d, actual %0d",
                 $time, want.match_score, got.match_score);
        error_count++;
      end
      if (got.query_found !== want.query_found) begin
        $display("%0t: query_found mismatch, expected %0d, actual %0d",
                 $time, want.query_found, got.query_found);
        error_count++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [fms_pkg::CIDX_W-1:0] cfg_index;
  logic [fms_pkg::CFG_W-1:0]  cfg_data;

  fms_char_if   char_ch();
  fms_result_if result_ch();

  fuzzy_match_scorer_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_in    (char_ch),
    .result_out (result_ch)
  );

  fuzzy_score_checker book = new();

  // bench copy of the active query, used only to shape the text
  logic [7:0]  query_bytes [QUERY_MAX];
  int unsigned query_span = 0;
  int unsigned chars_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic load_query(logic [fms_pkg::CFG_W-1:0] low, logic [fms_pkg::CFG_W-1:0] high,
                            logic [fms_pkg::POS_W-1:0] len);
    cfg_write <= 1'b1;
    cfg_index <= fms_pkg::REG_QUERY_LOW;
    cfg_data  <= low;
    @(posedge clk);
    cfg_index <= fms_pkg::REG_QUERY_HIGH;
    cfg_data  <= high;
    @(posedge clk);
    cfg_index <= fms_pkg::REG_QUERY_LEN;
    cfg_data  <= fms_pkg::CFG_W'(len);
    @(posedge clk);
    cfg_write <= 1'b0;
    book.set_register(fms_pkg::REG_QUERY_LOW, low);
    book.set_register(fms_pkg::REG_QUERY_HIGH, high);
    book.set_register(fms_pkg::REG_QUERY_LEN, fms_pkg::CFG_W'(len));
    for (int i = 0; i < 8; i++) begin
      query_bytes[i]     = low[8*i +: 8];
      query_bytes[i + 8] = high[8*i +: 8];
    end
    query_span = (len > QUERY_MAX) ? QUERY_MAX : len;
  endtask

  task automatic send_char(logic [fms_pkg::CHAR_W-1:0] c, logic last, int unsigned gap);
    repeat (gap) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.text_char <= c;
    char_ch.last_char <= last;
    do @(posedge clk); while (char_ch.ready !== 1'b1);
    book.take_char(c, last);
    chars_sent++;
  endtask

  task automatic send_span(logic [fms_pkg::CHAR_W-1:0] text [$], int unsigned lo,
                           int unsigned hi, bit steady);
    for (int unsigned i = lo; i < hi; i++)
      send_char(text[i], i == text.size() - 1, steady ? 0 : $urandom_range(0, 5));
  endtask

  // Drop valid, let every owed score drain, then give the pipeline time to settle.
  task automatic wait_quiet();
    char_ch.valid <= 1'b0;
    do @(posedge clk); while (book.waiting() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 4))
      0:       return 8'h20;
      1:       return 8'h2D;
      2:       return 8'h5F;
      3:       return 8'h2E;
      default: return 8'h2F;
    endcase
  endfunction

  function automatic logic [7:0] pick_query_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6)       return 8'h61 + 8'($urandom_range(0, 25));
    else if (r == 6) return 8'h30 + 8'($urandom_range(0, 9));
    else if (r == 7) return pick_separator();
    else             return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [fms_pkg::CHAR_W-1:0] pick_filler();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8)       return {8'h00, pick_separator()};
    else if (r < 14) return 16'h0061 + 16'($urandom_range(0, 25));
    else if (r == 14) return 16'h0030 + 16'($urandom_range(0, 9));
    else if (r == 15) return 16'h0041 + 16'($urandom_range(0, 25));
    else if (r < 18) return {8'h00, query_bytes[$urandom_range(0, QUERY_MAX - 1)]};
    else if (r == 18) return 16'($urandom_range(0, 65535));
    // low byte equals a query character, upper byte nonzero: must not match
    else return {8'($urandom_range(1, 255)), query_bytes[$urandom_range(0, QUERY_MAX - 1)]};
  endfunction

  // Mostly the query spread out with fillers; some strings lose one query
  // character, some are plain noise. pad_to stretches the string for saturation.
  task automatic build_text(output logic [fms_pkg::CHAR_W-1:0] text [$],
                            input int unsigned pad_to, input bit pad_front);
    int unsigned kind;
    int unsigned skip;
    text = {};
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      skip = (kind == 7 && query_span > 0) ? $urandom_range(0, query_span - 1) : QUERY_MAX;
      for (int i = 0; i < query_span; i++) begin
        repeat ($urandom_range(0, 2)) text.insert(text.size(), pick_filler());
        if (i != skip) text.insert(text.size(), {8'h00, query_bytes[i]});
      end
      repeat ($urandom_range(0, 3)) text.insert(text.size(), pick_filler());
    end else begin
      repeat ($urandom_range(1, 20)) text.insert(text.size(), pick_filler());
    end
    while (text.size() < pad_to) begin
      if (pad_front) text.push_front(pick_filler());
      else text.insert(text.size(), pick_filler());
    end
    if (text.size() == 0) text.insert(0, pick_filler());
  endtask

  task automatic load_random_query();
    logic [fms_pkg::CFG_W-1:0] low;
    logic [fms_pkg::CFG_W-1:0] high;
    logic [fms_pkg::POS_W-1:0] len;
    int unsigned               pick;
    for (int i = 0; i < 8; i++) begin
      low[8*i +: 8]  = pick_query_byte();
      high[8*i +: 8] = pick_query_byte();
    end
    pick = $urandom_range(0, 19);
    if (pick == 0)       len = '0;
    else if (pick < 12)  len = fms_pkg::POS_W'($urandom_range(1, 8));
    else if (pick < 15)  len = fms_pkg::POS_W'(QUERY_MAX);
    else if (pick < 17)  len = fms_pkg::POS_W'($urandom_range(17, 31));
    else                 len = fms_pkg::POS_W'($urandom_range(9, 15));
    load_query(low, high, len);
  endtask

  task automatic run_directed();
    // query registers still at reset: empty query, found with score zero
    send_char(16'hFFFF, 1'b1, 0);
    wait_quiet();
    // query "ab"
    load_query(64'hFFFF_FFFF_FFFF_6261, '0, 5'd2);
    send_char(16'h0061, 1'b0, 0);
    send_char(16'h0062, 1'b1, 0);
    // "x", aliased 'a' with a high byte, "a", space, "b": boundaries and a broken run
    send_char(16'h0078, 1'b0, 1);
    send_char(16'h0161, 1'b0, 2);
    send_char(16'h0061, 1'b0, 0);
    send_char(16'h0020, 1'b0, 3);
    send_char(16'h0062, 1'b1, 0);
    // query never completed
    send_char(16'h0062, 1'b1, 1);
    // shrink the query while a string is open: position already at the new length
    send_char(16'h0061, 1'b0, 0);
    wait_quiet();
    load_query(64'hFFFF_FFFF_FFFF_6261, '0, 5'd1);
    send_char(16'h0000, 1'b1, 0);
    wait_quiet();
    // length above the query size clamps; extreme bytes, one unbroken run
    load_query(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 5'd31);
    for (int i = 0; i < QUERY_MAX; i++)
      send_char({8'h00, query_bytes[i]}, i == QUERY_MAX - 1, 0);
    wait_quiet();
  endtask

  initial begin : score_sink
    int unsigned      stall;
    int unsigned      steady;
    fms_pkg::result_t got;
    result_ch.ready <= 1'b0;
    steady = 0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (steady > 0) begin
        stall = 0;
        steady--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall  = 0;
        steady = $urandom_range(5, 15);
      end else begin
        stall = $urandom_range(0, 5);
      end
      repeat (stall) begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
      got.match_score = result_ch.match_score;
      got.query_found = result_ch.query_found;
      book.check_score(got);
    end
  end

  initial begin : stimulus
    logic [fms_pkg::CHAR_W-1:0] text [$];
    int unsigned                random_from;
    int unsigned                round;
    int unsigned                strings;
    int unsigned                pad;
    int unsigned                split;
    bit                         steady;
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_index         <= fms_pkg::REG_QUERY_LOW;
    cfg_data          <= '0;
    char_ch.valid     <= 1'b0;
    char_ch.text_char <= '0;
    char_ch.last_char <= 1'b0;
    for (int i = 0; i < QUERY_MAX; i++) query_bytes[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    random_from = chars_sent;
    round = 0;
    while (chars_sent - random_from < RANDOM_CHARS) begin
      wait_quiet();
      load_random_query();
      strings = $urandom_range(4, 12);
      for (int s = 0; s < strings; s++) begin
        // a couple of strings run past the length counter's saturation point
        pad = ((round == 1 || round == 4) && s == 0) ? $urandom_range(257, 270) : 0;
        build_text(text, pad, round == 4);
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0 && text.size() > 1) begin
          split = $urandom_range(1, text.size() - 1);
          send_span(text, 0, split, steady);
          wait_quiet();
          load_random_query();
          send_span(text, split, text.size(), steady);
        end else begin
          send_span(text, 0, text.size(), steady);
        end
        if ($urandom_range(0, 7) == 0) wait_quiet();
      end
      round++;
    end

    wait_quiet();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (book.error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
